/* rtl/cpu_exu_pkg.sv */
`timescale 1ns / 1ps
// types, codes and helpers for the instruction execute unit
// no dependencies; imported by cpu6502_execute_unit and its checker

package cpu_exu_pkg;

    // operation codes, mnemonics in alphabetical order (no break instruction)
    typedef enum logic [5:0] {
        ACT_ADC = 6'd0,  ACT_AND = 6'd1,  ACT_ASL = 6'd2,  ACT_BCC = 6'd3,
        ACT_BCS = 6'd4,  ACT_BEQ = 6'd5,  ACT_BIT = 6'd6,  ACT_BMI = 6'd7,
        ACT_BNE = 6'd8,  ACT_BPL = 6'd9,  ACT_BVC = 6'd10, ACT_BVS = 6'd11,
        ACT_CLC = 6'd12, ACT_CLD = 6'd13, ACT_CLI = 6'd14, ACT_CLV = 6'd15,
        ACT_CMP = 6'd16, ACT_CPX = 6'd17, ACT_CPY = 6'd18, ACT_DEC = 6'd19,
        ACT_DEX = 6'd20, ACT_DEY = 6'd21, ACT_EOR = 6'd22, ACT_INC = 6'd23,
        ACT_INX = 6'd24, ACT_INY = 6'd25, ACT_JMP = 6'd26, ACT_JSR = 6'd27,
        ACT_LDA = 6'd28, ACT_LDX = 6'd29, ACT_LDY = 6'd30, ACT_LSR = 6'd31,
        ACT_NOP = 6'd32, ACT_ORA = 6'd33, ACT_PHA = 6'd34, ACT_PHP = 6'd35,
        ACT_PLA = 6'd36, ACT_PLP = 6'd37, ACT_ROL = 6'd38, ACT_ROR = 6'd39,
        ACT_RTI = 6'd40, ACT_RTS = 6'd41, ACT_SBC = 6'd42, ACT_SEC = 6'd43,
        ACT_SED = 6'd44, ACT_SEI = 6'd45, ACT_STA = 6'd46, ACT_STX = 6'd47,
        ACT_STY = 6'd48, ACT_TAX = 6'd49, ACT_TAY = 6'd50, ACT_TSX = 6'd51,
        ACT_TXA = 6'd52, ACT_TXS = 6'd53, ACT_TYA = 6'd54
    } action_t;

    // memory write kinds
    typedef enum logic [1:0] {
        WK_NONE  = 2'd0,
        WK_STORE = 2'd1,
        WK_PUSH  = 2'd2
    } write_kind_t;

    // input word layout, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] fallthrough_pc;
        logic [15:0] effective_address;
        logic [15:0] pulled_word;
        logic [7:0]  data_byte;
        logic [5:0]  action;
    } in_item_t;

    // output word layout, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0]  sp_out;
        logic [7:0]  y_out;
        logic [7:0]  x_out;
        logic [7:0]  acc_out;
        logic [7:0]  status_byte;
        logic [15:0] next_pc;
        logic [7:0]  write_data;
        logic [15:0] write_address;
    } out_item_t;

    localparam logic [7:0] STACK_PAGE  = 8'h01;
    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] BREAK_BIT   = 8'h10;

    // flags packed as N V 1 B D I Z C, B reads as zero
    function automatic logic [7:0] pack_status(
        input logic n, input logic v, input logic d,
        input logic i, input logic z, input logic c);
        pack_status = {n, v, 1'b1, 1'b0, d, i, z, c};
    endfunction

endpackage

/* rtl/cpu6502_execute_unit.sv */
`timescale 1ns / 1ps
// execute unit: input register, one pass of instruction logic, result register
// depends on cpu_exu_pkg
//
//  channel   dir  tdata                          tuser / tlast
//  s_axis    in   instruction word (64 bits)     tuser: accumulator_mode
//  m_axis    out  write and register state (80)  tuser: write_kind, tlast: last
//
// an instruction waits in the input register and is executed as it
// moves into the result register: one result per cycle while the output is not
// stalled, a subroutine call gives two results (two pushes) from the input register
// result valid is registered from the input valid, so a result can be taken
// once its instruction has passed the input register and the result register
// reset clears both valid bits and sets the architectural registers
// a stalled result holds; the input side takes a new word in the same cycle
// as the result register drains, except while a call makes its first push

module cpu6502_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[5:0], data_byte[13:6], pulled_word[29:14],
    // effective_address[45:30], fallthrough_pc[61:46], zero fill
    input  logic [63:0] s_axis_tdata,
    // accumulator_mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // write_address[15:0], write_data[23:16], next_pc[39:24],
    // status_byte[47:40], acc_out[55:48], x_out[63:56], y_out[71:64], sp_out[79:72]
    output logic [79:0] m_axis_tdata,
    // write_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import cpu_exu_pkg::*;

    // input stage
    logic        in_vld_reg;
    in_item_t    in_item_reg;
    logic        in_amode_reg;
    logic        jsr_phase_reg;

    // result stage
    logic        out_vld_reg;
    out_item_t   out_item_reg;
    write_kind_t out_kind_reg;
    logic        out_last_reg;

    // architectural state
    logic [7:0]  acc_reg, x_reg, y_reg, sp_reg;
    logic [15:0] pc_reg;
    logic        c_reg, z_reg, i_reg, d_reg, v_reg, n_reg;

    logic [7:0]  acc_next, x_next, y_next, sp_next;
    logic [15:0] pc_next;
    logic        c_next, z_next, i_next, d_next, v_next, n_next;

    action_t     act;
    logic        is_jsr;
    logic        out_load;
    logic        advance;

    write_kind_t wk;
    logic [15:0] waddr;
    logic [7:0]  wdata;

    logic [7:0]  m;
    logic [7:0]  add_b;
    logic [8:0]  sum9;
    logic [7:0]  cmp_reg;
    logic [8:0]  diff9;
    logic [7:0]  shift_in;
    logic [7:0]  shift_res;
    logic        shift_c;
    logic [7:0]  incdec;
    logic [15:0] ret_addr;
    logic        taken;
    logic [7:0]  zn_val;
    logic        zn_set;

    assign act    = action_t'(in_item_reg.action);
    assign m      = in_item_reg.data_byte;
    assign is_jsr = (act == ACT_JSR);

    // flow control: the result register loads when empty or draining
    assign out_load      = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign advance       = out_load && (!is_jsr || jsr_phase_reg);
    assign s_axis_tready = !in_vld_reg || advance;

    // shared datapath pieces
    assign add_b    = (act == ACT_SBC) ? ~m : m;
    assign sum9     = {1'b0, acc_reg} + {1'b0, add_b} + {8'd0, c_reg};
    assign diff9    = {1'b0, cmp_reg} - {1'b0, m};
    assign shift_in = in_amode_reg ? acc_reg : m;
    assign incdec   = (act == ACT_DEC) ? (m - 8'd1) : (m + 8'd1);
    assign ret_addr = in_item_reg.fallthrough_pc - 16'd1;

    // compare source register
    always_comb
    begin
        unique case (act)
            ACT_CPX: cmp_reg = x_reg;
            ACT_CPY: cmp_reg = y_reg;
            default: cmp_reg = acc_reg;
        endcase
    end

    // shifts and rotates
    always_comb
    begin
        unique case (act)
            ACT_ASL:
            begin
                shift_res = {shift_in[6:0], 1'b0};
                shift_c   = shift_in[7];
            end
            ACT_ROL:
            begin
                shift_res = {shift_in[6:0], c_reg};
                shift_c   = shift_in[7];
            end
            ACT_ROR:
            begin
                shift_res = {c_reg, shift_in[7:1]};
                shift_c   = shift_in[0];
            end
            default:
            begin
                shift_res = {1'b0, shift_in[7:1]};
                shift_c   = shift_in[0];
            end
        endcase
    end

    // instruction execution: next state and the memory write
    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        pc_next  = in_item_reg.fallthrough_pc;
        c_next   = c_reg;
        z_next   = z_reg;
        i_next   = i_reg;
        d_next   = d_reg;
        v_next   = v_reg;
        n_next   = n_reg;
        wk       = WK_NONE;
        waddr    = 16'd0;
        wdata    = 8'd0;
        taken    = 1'b0;
        zn_set   = 1'b0;
        zn_val   = 8'd0;

        unique case (act)
            ACT_ADC, ACT_SBC:
            begin
                acc_next = sum9[7:0];
                c_next   = sum9[8];
                v_next   = ~(acc_reg[7] ^ add_b[7]) & (acc_reg[7] ^ sum9[7]);
                zn_set   = 1'b1;
                zn_val   = sum9[7:0];
            end
            ACT_AND:
            begin
                acc_next = acc_reg & m;
                zn_set   = 1'b1;
                zn_val   = acc_reg & m;
            end
            ACT_ORA:
            begin
                acc_next = acc_reg | m;
                zn_set   = 1'b1;
                zn_val   = acc_reg | m;
            end
            ACT_EOR:
            begin
                acc_next = acc_reg ^ m;
                zn_set   = 1'b1;
                zn_val   = acc_reg ^ m;
            end
            ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR:
            begin
                c_next = shift_c;
                zn_set = 1'b1;
                zn_val = shift_res;
                if (in_amode_reg)
                begin
                    acc_next = shift_res;
                end
                else
                begin
                    wk    = WK_STORE;
                    waddr = in_item_reg.effective_address;
                    wdata = shift_res;
                end
            end
            ACT_BCC: taken = !c_reg;
            ACT_BCS: taken = c_reg;
            ACT_BEQ: taken = z_reg;
            ACT_BNE: taken = !z_reg;
            ACT_BMI: taken = n_reg;
            ACT_BPL: taken = !n_reg;
            ACT_BVC: taken = !v_reg;
            ACT_BVS: taken = v_reg;
            ACT_BIT:
            begin
                z_next = ((acc_reg & m) == 8'd0);
                n_next = m[7];
                v_next = m[6];
            end
            ACT_CLC: c_next = 1'b0;
            ACT_CLD: d_next = 1'b0;
            ACT_CLI: i_next = 1'b0;
            ACT_CLV: v_next = 1'b0;
            ACT_SEC: c_next = 1'b1;
            ACT_SED: d_next = 1'b1;
            ACT_SEI: i_next = 1'b1;
            ACT_CMP, ACT_CPX, ACT_CPY:
            begin
                c_next = !diff9[8];
                zn_set = 1'b1;
                zn_val = diff9[7:0];
            end
            ACT_DEC, ACT_INC:
            begin
                zn_set = 1'b1;
                zn_val = incdec;
                wk     = WK_STORE;
                waddr  = in_item_reg.effective_address;
                wdata  = incdec;
            end
            ACT_DEX:
            begin
                x_next = x_reg - 8'd1;
                zn_set = 1'b1;
                zn_val = x_reg - 8'd1;
            end
            ACT_DEY:
            begin
                y_next = y_reg - 8'd1;
                zn_set = 1'b1;
                zn_val = y_reg - 8'd1;
            end
            ACT_INX:
            begin
                x_next = x_reg + 8'd1;
                zn_set = 1'b1;
                zn_val = x_reg + 8'd1;
            end
            ACT_INY:
            begin
                y_next = y_reg + 8'd1;
                zn_set = 1'b1;
                zn_val = y_reg + 8'd1;
            end
            ACT_JMP: pc_next = in_item_reg.effective_address;
            ACT_JSR:
            begin
                // high byte pushed first, low byte on the second pass
                pc_next = in_item_reg.effective_address;
                sp_next = sp_reg - 8'd2;
                wk      = WK_PUSH;
                if (jsr_phase_reg)
                begin
                    waddr = {STACK_PAGE, sp_reg - 8'd1};
                    wdata = ret_addr[7:0];
                end
                else
                begin
                    waddr = {STACK_PAGE, sp_reg};
                    wdata = ret_addr[15:8];
                end
            end
            ACT_LDA:
            begin
                acc_next = m;
                zn_set   = 1'b1;
                zn_val   = m;
            end
            ACT_LDX:
            begin
                x_next = m;
                zn_set = 1'b1;
                zn_val = m;
            end
            ACT_LDY:
            begin
                y_next = m;
                zn_set = 1'b1;
                zn_val = m;
            end
            ACT_PHA, ACT_PHP:
            begin
                wk      = WK_PUSH;
                waddr   = {STACK_PAGE, sp_reg};
                wdata   = (act == ACT_PHA) ? acc_reg :
                          (pack_status(n_reg, v_reg, d_reg, i_reg, z_reg, c_reg) | BREAK_BIT);
                sp_next = sp_reg - 8'd1;
            end
            ACT_PLA:
            begin
                sp_next  = sp_reg + 8'd1;
                acc_next = m;
                zn_set   = 1'b1;
                zn_val   = m;
            end
            ACT_PLP, ACT_RTI:
            begin
                // bits 5 and 4 of the pulled byte are dropped
                sp_next = (act == ACT_RTI) ? sp_reg + 8'd3 : sp_reg + 8'd1;
                n_next  = m[7];
                v_next  = m[6];
                d_next  = m[3];
                i_next  = m[2];
                z_next  = m[1];
                c_next  = m[0];
                if (act == ACT_RTI)
                begin
                    pc_next = in_item_reg.pulled_word;
                end
            end
            ACT_RTS:
            begin
                sp_next = sp_reg + 8'd2;
                pc_next = in_item_reg.pulled_word + 16'd1;
            end
            ACT_STA, ACT_STX, ACT_STY:
            begin
                wk    = WK_STORE;
                waddr = in_item_reg.effective_address;
                wdata = (act == ACT_STA) ? acc_reg : ((act == ACT_STX) ? x_reg : y_reg);
            end
            ACT_TAX:
            begin
                x_next = acc_reg;
                zn_set = 1'b1;
                zn_val = acc_reg;
            end
            ACT_TAY:
            begin
                y_next = acc_reg;
                zn_set = 1'b1;
                zn_val = acc_reg;
            end
            ACT_TSX:
            begin
                x_next = sp_reg;
                zn_set = 1'b1;
                zn_val = sp_reg;
            end
            ACT_TXA:
            begin
                acc_next = x_reg;
                zn_set   = 1'b1;
                zn_val   = x_reg;
            end
            ACT_TYA:
            begin
                acc_next = y_reg;
                zn_set   = 1'b1;
                zn_val   = y_reg;
            end
            ACT_TXS: sp_next = x_reg;
            default: ;
        endcase

        if (taken)
        begin
            pc_next = in_item_reg.effective_address;
        end
        if (zn_set)
        begin
            z_next = (zn_val == 8'd0);
            n_next = zn_val[7];
        end
    end

    // input register and call phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            jsr_phase_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                jsr_phase_reg <= 1'b0;
            end
            else if (out_load && is_jsr)
            begin
                jsr_phase_reg <= 1'b1;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg  <= in_item_t'(s_axis_tdata);
            in_amode_reg <= s_axis_tuser;
        end
    end

    // architectural state, committed once per instruction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
            sp_reg  <= SP_RESET;
            pc_reg  <= 16'd0;
            c_reg   <= 1'b0;
            z_reg   <= 1'b0;
            i_reg   <= 1'b1;
            d_reg   <= 1'b0;
            v_reg   <= 1'b0;
            n_reg   <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            sp_reg  <= sp_next;
            pc_reg  <= pc_next;
            c_reg   <= c_next;
            z_reg   <= z_next;
            i_reg   <= i_next;
            d_reg   <= d_next;
            v_reg   <= v_next;
            n_reg   <= n_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // result payload, carries the state after the instruction
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg.write_address <= waddr;
            out_item_reg.write_data    <= wdata;
            out_item_reg.next_pc       <= pc_next;
            out_item_reg.status_byte   <= pack_status(n_next, v_next, d_next,
                                                      i_next, z_next, c_next);
            out_item_reg.acc_out       <= acc_next;
            out_item_reg.x_out         <= x_next;
            out_item_reg.y_out         <= y_next;
            out_item_reg.sp_out        <= sp_next;
            out_kind_reg               <= wk;
            out_last_reg               <= !is_jsr || jsr_phase_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_item_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/cpu_exu_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the execute unit, bound into cpu6502_execute_unit
// depends on cpu_exu_pkg and cpu6502_execute_unit

module cpu_exu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import cpu_exu_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // no write means zero address and data
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == WK_NONE |-> m_axis_tdata[23:0] == 24'd0)
        else $error("empty write carries address or data");

    // pushes land in the stack page
    a_push_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == WK_PUSH |-> m_axis_tdata[15:8] == STACK_PAGE)
        else $error("push outside the stack page");

    // only the first push of a call is not last
    a_first_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == WK_PUSH)
        else $error("non-last word is not a push");

    // second push of a call follows at once, one byte below, same state
    a_second_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast && m_axis_tuser == WK_PUSH &&
            m_axis_tdata[7:0] == $past(m_axis_tdata[7:0]) - 8'd1 &&
            m_axis_tdata[79:24] == $past(m_axis_tdata[79:24]))
        else $error("call push pair broken");

endmodule

bind cpu6502_execute_unit cpu_exu_checker u_cpu_exu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
